// ----- rtl/ifp_pkg.sv -----
package ifp_pkg;

  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_SYNC_FIRST   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_SECOND  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ANGLE_ID     = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_EULER_LENGTH = 2'd3;

  localparam logic [7:0] SYNC_FIRST_RST   = 8'h59;
  localparam logic [7:0] SYNC_SECOND_RST  = 8'h53;
  localparam logic [7:0] ANGLE_ID_RST     = 8'd64;
  localparam logic [7:0] EULER_LENGTH_RST = 8'd12;

  // bytes of pitch, roll and yaw together
  localparam int          ShadowBytes = 12;
  localparam logic [7:0]  SHADOW_BYTES = 8'd12;

  typedef enum logic [2:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_TIDLO,
    PH_TIDHI,
    PH_LEN,
    PH_PAYLOAD,
    PH_CKA,
    PH_CKB
  } phase_t;

  typedef enum logic [1:0] {
    SP_ID,
    SP_LEN,
    SP_DATA
  } sub_phase_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] angle_id;
    logic [7:0] euler_length;
  } cfg_t;

  // classified byte as it travels through the queue
  typedef struct packed {
    logic [7:0] data;
    logic       is_sync1;
    logic       is_sync2;
    logic       is_eid;
    logic       is_elen;
  } item_t;

endpackage

// ----- rtl/ifp_front.sv -----
module ifp_front
  import ifp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_pop
);

  item_t      q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  item_t      cls;

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = q_r[rd_ptr_r];

  always_comb begin
    cls.data     = in_rx_byte;
    cls.is_sync1 = (in_rx_byte == cfg.sync_first);
    cls.is_sync2 = (in_rx_byte == cfg.sync_second);
    cls.is_eid   = (in_rx_byte == cfg.angle_id);
    cls.is_elen  = (in_rx_byte == cfg.euler_length);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
      case ({push, q_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- rtl/ifp_back.sv -----
module ifp_back
  import ifp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_frame_status,
  output logic [15:0]        out_frame_tid,
  output logic               out_euler_seen,
  output logic signed [31:0] out_pitch_raw,
  output logic signed [31:0] out_roll_raw,
  output logic signed [31:0] out_yaw_raw
);

  phase_t     phase_r, phase_nxt;
  sub_phase_t sub_phase_r, sub_phase_nxt;
  logic [7:0] byte_count_r, byte_count_nxt;
  logic [7:0] payload_len_r, payload_len_nxt;
  logic [7:0] sum_a_r, sum_a_nxt;
  logic [7:0] sum_b_r, sum_b_nxt;
  logic [7:0] check_low_r, check_low_nxt;
  logic [15:0] tid_r, tid_nxt;
  logic [7:0] sub_cnt_r, sub_cnt_nxt;
  logic       found_r, found_nxt;
  logic [7:0] shadow_r [ShadowBytes];

  logic       out_valid_r;
  logic       out_status_r;
  logic [15:0] out_tid_r;
  logic       out_seen_r;
  logic [31:0] ang_r [3];

  logic       out_free;
  logic       shadow_we;
  logic [3:0] shadow_idx;
  logic       emit;
  logic       ok;
  logic [7:0] b;
  logic [7:0] add_a;
  logic [7:0] add_b;
  logic [7:0] cnt_inc;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = q_valid && ((phase_r != PH_CKB) || out_free);
  assign b        = q_item.data;
  assign add_a    = sum_a_r + b;
  assign add_b    = sum_b_r + add_a;
  assign cnt_inc  = sub_cnt_r + 8'd1;
  assign ok       = (check_low_r == sum_a_r) && (b == sum_b_r);

  always_comb begin
    phase_nxt       = phase_r;
    sub_phase_nxt   = sub_phase_r;
    byte_count_nxt  = byte_count_r;
    payload_len_nxt = payload_len_r;
    sum_a_nxt       = sum_a_r;
    sum_b_nxt       = sum_b_r;
    check_low_nxt   = check_low_r;
    tid_nxt         = tid_r;
    sub_cnt_nxt     = sub_cnt_r;
    found_nxt       = found_r;
    shadow_we       = 1'b0;
    shadow_idx      = sub_cnt_r[3:0];
    emit            = 1'b0;
    if (q_pop) begin
      unique case (phase_r)
        PH_HUNT1: begin
          if (q_item.is_sync1) phase_nxt = PH_HUNT2;
        end
        PH_HUNT2: begin
          if (q_item.is_sync2) begin
            phase_nxt = PH_TIDLO;
            sum_a_nxt = 8'd0;
            sum_b_nxt = 8'd0;
          end else if (!q_item.is_sync1) begin
            phase_nxt = PH_HUNT1;
          end
        end
        PH_TIDLO: begin
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          tid_nxt   = {8'd0, b};
          phase_nxt = PH_TIDHI;
        end
        PH_TIDHI: begin
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          tid_nxt   = {b, tid_r[7:0]};
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          sum_a_nxt       = add_a;
          sum_b_nxt       = add_b;
          payload_len_nxt = b;
          byte_count_nxt  = 8'd0;
          sub_phase_nxt   = SP_ID;
          sub_cnt_nxt     = 8'd0;
          found_nxt       = 1'b0;
          phase_nxt       = (b == 8'd0) ? PH_CKA : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          sum_a_nxt      = add_a;
          sum_b_nxt      = add_b;
          byte_count_nxt = byte_count_r + 8'd1;
          if (byte_count_nxt == payload_len_r) phase_nxt = PH_CKA;
          unique case (sub_phase_r)
            SP_ID: begin
              if (q_item.is_eid) sub_phase_nxt = SP_LEN;
            end
            SP_LEN: begin
              if (q_item.is_elen) begin
                sub_cnt_nxt = 8'd0;
                if (cfg.euler_length == 8'd0) begin
                  found_nxt     = 1'b1;
                  sub_phase_nxt = SP_ID;
                end else begin
                  found_nxt     = 1'b0;
                  sub_phase_nxt = SP_DATA;
                end
              end else if (q_item.is_eid) begin
                sub_phase_nxt = SP_LEN;
              end else begin
                sub_phase_nxt = SP_ID;
              end
            end
            SP_DATA: begin
              shadow_we   = (sub_cnt_r < SHADOW_BYTES);
              sub_cnt_nxt = cnt_inc;
              if (cnt_inc == cfg.euler_length) begin
                found_nxt     = 1'b1;
                sub_phase_nxt = SP_ID;
              end
            end
            default: sub_phase_nxt = SP_ID;
          endcase
        end
        PH_CKA: begin
          check_low_nxt = b;
          phase_nxt     = PH_CKB;
        end
        PH_CKB: begin
          emit          = 1'b1;
          found_nxt     = 1'b0;
          sub_phase_nxt = SP_ID;
          phase_nxt     = PH_HUNT1;
        end
        default: phase_nxt = PH_HUNT1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HUNT1;
      sub_phase_r   <= SP_ID;
      byte_count_r  <= 8'd0;
      payload_len_r <= 8'd0;
      sum_a_r       <= 8'd0;
      sum_b_r       <= 8'd0;
      check_low_r   <= 8'd0;
      tid_r         <= 16'd0;
      sub_cnt_r     <= 8'd0;
      found_r       <= 1'b0;
      for (int i = 0; i < ShadowBytes; i++) shadow_r[i] <= 8'd0;
    end else begin
      phase_r       <= phase_nxt;
      sub_phase_r   <= sub_phase_nxt;
      byte_count_r  <= byte_count_nxt;
      payload_len_r <= payload_len_nxt;
      sum_a_r       <= sum_a_nxt;
      sum_b_r       <= sum_b_nxt;
      check_low_r   <= check_low_nxt;
      tid_r         <= tid_nxt;
      sub_cnt_r     <= sub_cnt_nxt;
      found_r       <= found_nxt;
      if (shadow_we) shadow_r[shadow_idx] <= b;
    end
  end

  // result register; the angle fields double as the committed angles
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      out_status_r <= 1'b0;
      out_tid_r    <= 16'd0;
      out_seen_r   <= 1'b0;
      for (int i = 0; i < 3; i++) ang_r[i] <= 32'd0;
    end else begin
      if (emit) begin
        out_valid_r  <= 1'b1;
        out_status_r <= !ok;
        out_tid_r    <= tid_r;
        out_seen_r   <= ok && found_r;
        if (ok && found_r) begin
          for (int i = 0; i < 3; i++) begin
            ang_r[i] <= {shadow_r[4*i+3], shadow_r[4*i+2], shadow_r[4*i+1], shadow_r[4*i]};
          end
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_status = out_status_r;
  assign out_frame_tid    = out_tid_r;
  assign out_euler_seen   = out_seen_r;
  assign out_pitch_raw    = $signed(ang_r[0]);
  assign out_roll_raw     = $signed(ang_r[1]);
  assign out_yaw_raw      = $signed(ang_r[2]);

endmodule

// ----- rtl/imu_frame_parser_euler.sv -----
// out_valid rises once the second check byte has left the byte queue and
// the parser step has loaded the result register. Throughput: one byte
// per cycle, set by the parser step behind a two-entry byte queue, while
// no finished frame waits on out_stall, which holds the result register.
// Reset (synchronous, rst_n low): registers return to their defaults, the
// parser hunts for the first sync byte, committed angles are zero.
module imu_frame_parser_euler
  import ifp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_frame_status,
  output logic [15:0]        out_frame_tid,
  output logic               out_euler_seen,
  output logic signed [31:0] out_pitch_raw,
  output logic signed [31:0] out_roll_raw,
  output logic signed [31:0] out_yaw_raw
);

  cfg_t  cfg_r;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first   <= SYNC_FIRST_RST;
      cfg_r.sync_second  <= SYNC_SECOND_RST;
      cfg_r.angle_id     <= ANGLE_ID_RST;
      cfg_r.euler_length <= EULER_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYNC_FIRST:   cfg_r.sync_first   <= cfg_wdata;
        CFG_SYNC_SECOND:  cfg_r.sync_second  <= cfg_wdata;
        CFG_ANGLE_ID:     cfg_r.angle_id     <= cfg_wdata;
        CFG_EULER_LENGTH: cfg_r.euler_length <= cfg_wdata;
        default:          cfg_r              <= cfg_r;
      endcase
    end
  end

  ifp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  ifp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_status (out_frame_status),
    .out_frame_tid    (out_frame_tid),
    .out_euler_seen   (out_euler_seen),
    .out_pitch_raw    (out_pitch_raw),
    .out_roll_raw     (out_roll_raw),
    .out_yaw_raw      (out_yaw_raw)
  );

endmodule

// ----- test/tb_imu_frame_parser_euler.sv -----
module tb_imu_frame_parser_euler;
  import ifp_pkg::*;

  localparam int QuietLimit  = 2000;
  localparam int PhaseBytes  = 80;
  localparam int PhaseFrames = 4;
  localparam int NumPhases   = 7;

  typedef struct packed {
    logic        status;
    logic [15:0] tid;
    logic        seen;
    logic [31:0] pitch;
    logic [31:0] roll;
    logic [31:0] yaw;
  } frame_result_t;

  typedef enum logic [1:0] {ROW_RAW, ROW_SUM_A, ROW_SUM_B} row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    logic [7:0]    data;
    logic          typed;
    frame_result_t want;
  } dir_row_t;

  localparam frame_result_t NoResult  = '0;
  localparam frame_result_t FirstGood = '{1'b0, 16'h1234, 1'b0, 32'h0, 32'h0, 32'h0};
  localparam frame_result_t BadCheck  = '{1'b1, 16'hFFFF, 1'b0, 32'h0, 32'h0, 32'h0};

  localparam int DirCount = 37;
  localparam dir_row_t DirRows [DirCount] = '{
    '{ROW_RAW, 8'h53, 1'b0, NoResult},
    // repeated first sync, empty payload
    '{ROW_RAW, 8'h59, 1'b0, NoResult},
    '{ROW_RAW, 8'h59, 1'b0, NoResult},
    '{ROW_RAW, 8'h53, 1'b0, NoResult},
    '{ROW_RAW, 8'h34, 1'b0, NoResult},
    '{ROW_RAW, 8'h12, 1'b0, NoResult},
    '{ROW_RAW, 8'h00, 1'b0, NoResult},
    '{ROW_RAW, 8'h46, 1'b0, NoResult},
    '{ROW_RAW, 8'hC0, 1'b1, FirstGood},
    // bad check bytes
    '{ROW_RAW, 8'h59, 1'b0, NoResult},
    '{ROW_RAW, 8'h53, 1'b0, NoResult},
    '{ROW_RAW, 8'hFF, 1'b0, NoResult},
    '{ROW_RAW, 8'hFF, 1'b0, NoResult},
    '{ROW_RAW, 8'h00, 1'b0, NoResult},
    '{ROW_RAW, 8'h00, 1'b0, NoResult},
    '{ROW_RAW, 8'h00, 1'b1, BadCheck},
    // euler sub-packet with extreme angles
    '{ROW_RAW, 8'h59, 1'b0, NoResult},
    '{ROW_RAW, 8'h53, 1'b0, NoResult},
    '{ROW_RAW, 8'h01, 1'b0, NoResult},
    '{ROW_RAW, 8'h80, 1'b0, NoResult},
    '{ROW_RAW, 8'h0E, 1'b0, NoResult},
    '{ROW_RAW, 8'h40, 1'b0, NoResult},
    '{ROW_RAW, 8'h0C, 1'b0, NoResult},
    '{ROW_RAW, 8'h00, 1'b0, NoResult},
    '{ROW_RAW, 8'h00, 1'b0, NoResult},
    '{ROW_RAW, 8'h00, 1'b0, NoResult},
    '{ROW_RAW, 8'h80, 1'b0, NoResult},
    '{ROW_RAW, 8'hFF, 1'b0, NoResult},
    '{ROW_RAW, 8'hFF, 1'b0, NoResult},
    '{ROW_RAW, 8'hFF, 1'b0, NoResult},
    '{ROW_RAW, 8'h7F, 1'b0, NoResult},
    '{ROW_RAW, 8'hFF, 1'b0, NoResult},
    '{ROW_RAW, 8'hFF, 1'b0, NoResult},
    '{ROW_RAW, 8'hFF, 1'b0, NoResult},
    '{ROW_RAW, 8'hFF, 1'b0, NoResult},
    '{ROW_SUM_A, 8'h00, 1'b0, NoResult},
    '{ROW_SUM_B, 8'h00, 1'b0, NoResult}
  };

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [7:0]         cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_rx_byte;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_frame_status;
  logic [15:0]        out_frame_tid;
  logic               out_euler_seen;
  logic signed [31:0] out_pitch_raw;
  logic signed [31:0] out_roll_raw;
  logic signed [31:0] out_yaw_raw;

  imu_frame_parser_euler dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_status (out_frame_status),
    .out_frame_tid    (out_frame_tid),
    .out_euler_seen   (out_euler_seen),
    .out_pitch_raw    (out_pitch_raw),
    .out_roll_raw     (out_roll_raw),
    .out_yaw_raw      (out_yaw_raw)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted parser state
  logic [7:0]  cfg_reg [4];
  phase_t      pr_phase;
  sub_phase_t  pr_walk;
  logic [7:0]  pr_taken, pr_len, pr_sum_a, pr_sum_b, pr_ck_lo, pr_data_idx;
  logic [15:0] pr_tid;
  logic [31:0] pr_shadow [3];
  logic [31:0] pr_angles [3];
  logic        pr_found;

  frame_result_t pending_frames [$];
  int          err_count = 0;
  int          bytes_sent = 0;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  bit          idle_on = 1'b1;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    $display("mismatch %s: got %0h want %0h", what, got, want);
  endtask

  task automatic fold_sum(input logic [7:0] b);
    pr_sum_a = pr_sum_a + b;
    pr_sum_b = pr_sum_b + pr_sum_a;
  endtask

  task automatic parse_rx_byte(input logic [7:0] b, output logic done,
                               output frame_result_t res);
    logic ok;
    done = 1'b0;
    res  = '0;
    case (pr_phase)
      PH_HUNT1: begin
        if (b == cfg_reg[CFG_SYNC_FIRST]) pr_phase = PH_HUNT2;
      end
      PH_HUNT2: begin
        if (b == cfg_reg[CFG_SYNC_SECOND]) begin
          pr_phase = PH_TIDLO;
          pr_sum_a = '0;
          pr_sum_b = '0;
        end else if (b != cfg_reg[CFG_SYNC_FIRST]) begin
          pr_phase = PH_HUNT1;
        end
      end
      PH_TIDLO: begin
        fold_sum(b);
        pr_tid   = {8'h00, b};
        pr_phase = PH_TIDHI;
      end
      PH_TIDHI: begin
        fold_sum(b);
        pr_tid[15:8] = b;
        pr_phase     = PH_LEN;
      end
      PH_LEN: begin
        fold_sum(b);
        pr_len      = b;
        pr_taken    = '0;
        pr_walk     = SP_ID;
        pr_data_idx = '0;
        pr_found    = 1'b0;
        pr_phase    = (b == 8'd0) ? PH_CKA : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        fold_sum(b);
        case (pr_walk)
          SP_ID: begin
            if (b == cfg_reg[CFG_ANGLE_ID]) pr_walk = SP_LEN;
          end
          SP_LEN: begin
            if (b == cfg_reg[CFG_EULER_LENGTH]) begin
              pr_data_idx = '0;
              pr_found    = (cfg_reg[CFG_EULER_LENGTH] == 8'd0);
              pr_walk     = pr_found ? SP_ID : SP_DATA;
            end else if (b != cfg_reg[CFG_ANGLE_ID]) begin
              pr_walk = SP_ID;
            end
          end
          default: begin
            if (pr_data_idx < SHADOW_BYTES)
              pr_shadow[pr_data_idx[3:2]][{pr_data_idx[1:0], 3'b000} +: 8] = b;
            pr_data_idx = pr_data_idx + 8'd1;
            if (pr_data_idx == cfg_reg[CFG_EULER_LENGTH]) begin
              pr_found = 1'b1;
              pr_walk  = SP_ID;
            end
          end
        endcase
        pr_taken = pr_taken + 8'd1;
        if (pr_taken == pr_len) pr_phase = PH_CKA;
      end
      PH_CKA: begin
        pr_ck_lo = b;
        pr_phase = PH_CKB;
      end
      default: begin
        ok = (pr_ck_lo == pr_sum_a) && (b == pr_sum_b);
        if (ok && pr_found) pr_angles = pr_shadow;
        res.status = !ok;
        res.tid    = pr_tid;
        res.seen   = ok && pr_found;
        res.pitch  = pr_angles[0];
        res.roll   = pr_angles[1];
        res.yaw    = pr_angles[2];
        done       = 1'b1;
        pr_found   = 1'b0;
        pr_walk    = SP_ID;
        pr_phase   = PH_HUNT1;
      end
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b, input logic typed,
                           input frame_result_t want);
    logic          done;
    frame_result_t res;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    parse_rx_byte(b, done, res);
    if (typed) pending_frames.push_back(want);
    else if (done) pending_frames.push_back(res);
  endtask

  task automatic drain_parser();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_config(input logic [7:0] s1, input logic [7:0] s2,
                              input logic [7:0] eid, input logic [7:0] elen);
    logic [7:0] vals [4];
    vals[CFG_SYNC_FIRST]   = s1;
    vals[CFG_SYNC_SECOND]  = s2;
    vals[CFG_ANGLE_ID]     = eid;
    vals[CFG_EULER_LENGTH] = elen;
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CfgIdxW'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we  <= 1'b0;
    cfg_reg = vals;
  endtask

  // well-formed frame with random sub-packets; sometimes noisy, cut or corrupted
  task automatic send_frame();
    logic [7:0] frm [$];
    logic [7:0] sa, sb;
    logic [7:0] pl [$];
    int         kind, m, total, start;
    repeat (($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0)
      frm.push_back(8'($urandom));
    repeat ($urandom_range(0, 3)) begin
      kind = $urandom_range(0, 9);
      if (kind < 4 && (cfg_reg[CFG_EULER_LENGTH] <= 8'd24 || $urandom_range(0, 7) == 0)) begin
        pl.push_back(cfg_reg[CFG_ANGLE_ID]);
        pl.push_back(cfg_reg[CFG_EULER_LENGTH]);
        repeat (cfg_reg[CFG_EULER_LENGTH]) pl.push_back(8'($urandom));
      end else if (kind < 6) begin
        pl.push_back(cfg_reg[CFG_ANGLE_ID]);
        pl.push_back(8'($urandom));
      end else begin
        m = $urandom_range(0, 4);
        pl.push_back(8'($urandom));
        pl.push_back(8'(m));
        repeat (m) pl.push_back(8'($urandom));
      end
    end
    if (pl.size() > 0 && $urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, pl.size())) void'(pl.pop_back());
    while (pl.size() > 255) void'(pl.pop_back());
    frm.push_back(cfg_reg[CFG_SYNC_FIRST]);
    frm.push_back(cfg_reg[CFG_SYNC_SECOND]);
    start = frm.size();
    frm.push_back(8'($urandom));
    frm.push_back(8'($urandom));
    frm.push_back(8'(pl.size()));
    foreach (pl[i]) frm.push_back(pl[i]);
    sa = '0;
    sb = '0;
    for (int i = start; i < frm.size(); i++) begin
      sa = sa + frm[i];
      sb = sb + sa;
    end
    if ($urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 1) == 0) sa = sa ^ 8'(1 << $urandom_range(0, 7));
      else sb = sb ^ 8'(1 << $urandom_range(0, 7));
    end
    frm.push_back(sa);
    frm.push_back(sb);
    total = ($urandom_range(0, 15) == 0) ? $urandom_range(1, frm.size() - 1) : frm.size();
    for (int i = 0; i < total; i++) push_byte(frm[i], 1'b0, NoResult);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    frame_result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_frame_status, out_frame_tid, out_euler_seen,
              out_pitch_raw, out_roll_raw, out_yaw_raw};
      if (pending_frames.size() == 0) begin
        report_mismatch("result with none pending, tid", 32'(got.tid), 32'h0);
      end else begin
        want = pending_frames.pop_front();
        if (got.status !== want.status)
          report_mismatch("frame_status", 32'(got.status), 32'(want.status));
        if (got.tid !== want.tid)
          report_mismatch("frame_tid", 32'(got.tid), 32'(want.tid));
        if (got.seen !== want.seen)
          report_mismatch("euler_seen", 32'(got.seen), 32'(want.seen));
        if (got.pitch !== want.pitch) report_mismatch("pitch_raw", got.pitch, want.pitch);
        if (got.roll !== want.roll) report_mismatch("roll_raw", got.roll, want.roll);
        if (got.yaw !== want.yaw) report_mismatch("yaw_raw", got.yaw, want.yaw);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("tb_imu_frame_parser_euler: errors");
      $finish;
    end
  end

  initial begin
    logic [7:0] row_byte;
    int         frames, phase_start;
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= '0;
    cfg_wdata  <= '0;
    in_valid   <= 1'b0;
    in_rx_byte <= '0;
    cfg_reg[CFG_SYNC_FIRST]   = SYNC_FIRST_RST;
    cfg_reg[CFG_SYNC_SECOND]  = SYNC_SECOND_RST;
    cfg_reg[CFG_ANGLE_ID]     = ANGLE_ID_RST;
    cfg_reg[CFG_EULER_LENGTH] = EULER_LENGTH_RST;
    pr_phase    = PH_HUNT1;
    pr_walk     = SP_ID;
    pr_taken    = '0;
    pr_len      = '0;
    pr_sum_a    = '0;
    pr_sum_b    = '0;
    pr_ck_lo    = '0;
    pr_data_idx = '0;
    pr_tid      = '0;
    pr_found    = 1'b0;
    for (int i = 0; i < 3; i++) begin
      pr_shadow[i] = '0;
      pr_angles[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DirCount; i++) begin
      case (DirRows[i].kind)
        ROW_SUM_A: row_byte = pr_sum_a;
        ROW_SUM_B: row_byte = pr_sum_b;
        default:   row_byte = DirRows[i].data;
      endcase
      push_byte(row_byte, DirRows[i].typed, DirRows[i].want);
    end

    for (int p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        drain_parser();
        case (p)
          1: write_config(8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom_range(0, 16)));
          2: write_config(8'h00, 8'h00, 8'h00, 8'h00);
          3: write_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
          4: write_config(8'($urandom), 8'($urandom), ANGLE_ID_RST,
                          8'($urandom_range(13, 20)));
          5: write_config(8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom_range(1, 11)));
          default: write_config(SYNC_FIRST_RST, SYNC_SECOND_RST, ANGLE_ID_RST,
                                EULER_LENGTH_RST);
        endcase
      end
      idle_on     = (p < NumPhases - 1);
      phase_start = bytes_sent;
      frames      = 0;
      while (bytes_sent - phase_start < PhaseBytes || frames < PhaseFrames) begin
        send_frame();
        frames++;
      end
    end

    drain_parser();
    if (err_count == 0) begin
      $display("tb_imu_frame_parser_euler: clean");
    end else begin
      $display("tb_imu_frame_parser_euler: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ifp_pkg.sv
rtl/ifp_front.sv
rtl/ifp_back.sv
rtl/imu_frame_parser_euler.sv
test/tb_imu_frame_parser_euler.sv
